// ===== rtl/core/lirs_pkg.sv =====
package lirs_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int MAX_RUN_DEF     = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int OUT_DEPTH   = 4;

  // item classes decided at the input side
  localparam logic [1:0] KIND_STORE     = 2'd0;
  localparam logic [1:0] KIND_FIRST_EOB = 2'd1;
  localparam logic [1:0] KIND_RUN       = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic       eob;
  } lirs_ctl_t;

endpackage

// ===== rtl/core/linear_interp_resampler_unit.sv =====
// Channel    Handshake         Fields
// input      push / full       in_sample[SAMPLE_BITS], end_of_buffer
// result     pop / empty       out_sample[SAMPLE_BITS], run_last, buffer_done
// config     step_wr           step[FRAC_BITS+4]
//
// An item that only primes the first sample is taken in the back end's idle state.
// An item giving k results (k <= MAX_RUN) is loaded, then issues one result
// per cycle through the multiplier while the result queue has room, then
// closes; a buffer end going on from interpolated to held results closes twice.
// Issue stalls while the 4-entry result queue and multiplier stage are full;
// push stalls when the 2-entry input queue is full. Synchronous reset.
module linear_interp_resampler_unit #(
  parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lirs_pkg::FRAC_BITS_DEF,
  parameter int MAX_RUN     = lirs_pkg::MAX_RUN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step_wr,
  input  logic [FRAC_BITS+3:0]          step,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          end_of_buffer,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          run_last,
  output logic                          buffer_done
);
  import lirs_pkg::*;

  logic                          q_valid;
  lirs_ctl_t                     q_ctl;
  logic signed [SAMPLE_BITS-1:0] q_sample;
  logic                          q_take;

  lirs_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_sample    (in_sample),
    .end_of_buffer(end_of_buffer),
    .q_valid      (q_valid),
    .q_ctl        (q_ctl),
    .q_sample     (q_sample),
    .q_take       (q_take)
  );

  lirs_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .MAX_RUN    (MAX_RUN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .step_wr    (step_wr),
    .step       (step),
    .q_valid    (q_valid),
    .q_ctl      (q_ctl),
    .q_sample   (q_sample),
    .q_take     (q_take),
    .empty      (empty),
    .pop        (pop),
    .out_sample (out_sample),
    .run_last   (run_last),
    .buffer_done(buffer_done)
  );

endmodule

// ===== rtl/core/lirs_front.sv =====
module lirs_front #(
  parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          end_of_buffer,
  output logic                          q_valid,
  output lirs_pkg::lirs_ctl_t           q_ctl,
  output logic signed [SAMPLE_BITS-1:0] q_sample,
  input  logic                          q_take
);
  import lirs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  lirs_ctl_t                   ctl_mem [QUEUE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] smp_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]            wr_ptr;
  logic [PTR_W-1:0]            rd_ptr;
  logic [CNT_W-1:0]            count;
  logic                        have_prev;
  logic                        acc;
  logic                        deq;
  lirs_ctl_t                   new_ctl;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_ctl    = ctl_mem[rd_ptr];
  assign q_sample = smp_mem[rd_ptr];
  assign acc      = push && !full;
  assign deq      = q_take && q_valid;

  always_comb begin
    new_ctl.eob = end_of_buffer;
    if (have_prev) begin
      new_ctl.kind = KIND_RUN;
    end else if (end_of_buffer) begin
      new_ctl.kind = KIND_FIRST_EOB;
    end else begin
      new_ctl.kind = KIND_STORE;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ctl_mem[wr_ptr] <= new_ctl;
      smp_mem[wr_ptr] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      have_prev <= 1'b0;
    end else begin
      if (acc) begin
        wr_ptr    <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        have_prev <= !end_of_buffer;
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (acc && !deq) begin
        count <= count + 1'b1;
      end else if (deq && !acc) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/lirs_back.sv =====
module lirs_back #(
  parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lirs_pkg::FRAC_BITS_DEF,
  parameter int MAX_RUN     = lirs_pkg::MAX_RUN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step_wr,
  input  logic [FRAC_BITS+3:0]          step,
  input  logic                          q_valid,
  input  lirs_pkg::lirs_ctl_t           q_ctl,
  input  logic signed [SAMPLE_BITS-1:0] q_sample,
  output logic                          q_take,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          run_last,
  output logic                          buffer_done
);
  import lirs_pkg::*;

  localparam int STEP_W = FRAC_BITS + 4;
  localparam int POS_W  = FRAC_BITS + 6;
  localparam int N_W    = $clog2(MAX_RUN + 1);
  localparam int PROD_W = FRAC_BITS + SAMPLE_BITS + 2;
  localparam int OPTR_W = $clog2(OUT_DEPTH);
  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);
  localparam logic [POS_W-1:0] ONE = POS_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0] TWO = POS_W'(2) << FRAC_BITS;
  localparam logic [N_W-1:0]   NMAX = N_W'(MAX_RUN);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_INTERP = 2'd1;
  localparam logic [1:0] S_HELD   = 2'd2;

  logic [1:0]                    state;
  logic [STEP_W-1:0]             cur_step;
  logic signed [SAMPLE_BITS-1:0] prev;
  logic [POS_W-1:0]              position;
  logic signed [SAMPLE_BITS-1:0] cur_x;
  logic                          cur_eob;
  logic signed [SAMPLE_BITS:0]   diff;
  logic [N_W-1:0]                n;
  logic [POS_W-1:0]              pos;
  logic [POS_W-1:0]              psum;

  logic [POS_W-1:0] step_ext;
  logic [POS_W-1:0] psum2;
  logic [N_W-1:0]   n1;
  logic             pos_lt_one;
  logic             n_lt;
  logic             n1_lt;
  logic             nl_lt_one;
  logic             cond_i;
  logic             cont_i;
  logic             held_cont;
  logic             last_i;
  logic             cond_h;
  logic             last_h;
  logic             alive;
  logic [POS_W-1:0] pos_end;
  logic [POS_W-1:0] psum_end;
  logic             room;
  logic             issue;
  logic             issue_last;

  logic                          v1;
  logic signed [PROD_W-1:0]      prod;
  logic signed [SAMPLE_BITS-1:0] p_base;
  logic                          p_last;
  logic                          p_done;
  logic signed [SAMPLE_BITS+1:0] wsum;

  logic signed [SAMPLE_BITS-1:0] o_smp [OUT_DEPTH];
  logic                          o_last [OUT_DEPTH];
  logic                          o_done [OUT_DEPTH];
  logic [OPTR_W-1:0]             o_wr;
  logic [OPTR_W-1:0]             o_rd;
  logic [OCNT_W-1:0]             o_cnt;
  logic                          o_pop;

  assign step_ext   = POS_W'(cur_step);
  assign psum2      = psum + step_ext;
  assign n1         = n + 1'b1;
  assign pos_lt_one = (pos < ONE);
  assign n_lt       = (n < NMAX);
  assign n1_lt      = (n1 < NMAX);
  assign nl_lt_one  = (psum < ONE);

  assign cond_i    = pos_lt_one && n_lt && (!cur_eob || psum <= TWO);
  assign cont_i    = nl_lt_one && n1_lt && (!cur_eob || psum2 <= TWO);
  assign held_cont = cur_eob && !nl_lt_one && n1_lt && (psum2 <= TWO);
  assign last_i    = !cont_i && !held_cont;
  assign cond_h    = n_lt && (psum <= ONE);
  assign last_h    = !(n1_lt && (psum2 <= ONE));

  // end of interpolation run: run stopped by the tail limit is not alive
  assign alive    = !(pos_lt_one && n_lt);
  assign pos_end  = pos_lt_one ? '0 : pos - ONE;
  assign psum_end = pos_lt_one ? step_ext : psum - ONE;

  assign room  = ({1'b0, o_cnt} + (OCNT_W + 1)'(v1)) < (OCNT_W + 1)'(OUT_DEPTH);
  assign issue = room && (((state == S_INTERP) && cond_i) || ((state == S_HELD) && cond_h));
  assign issue_last = (state == S_INTERP) ? last_i : last_h;

  assign q_take = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_step <= STEP_W'(ONE);
    end else if (step_wr) begin
      cur_step <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      prev     <= '0;
      position <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            unique case (q_ctl.kind)
              KIND_STORE: begin
                prev <= q_sample;
              end
              KIND_FIRST_EOB: begin
                state <= S_HELD;
              end
              KIND_RUN: begin
                state <= S_INTERP;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_INTERP: begin
          if (!cond_i) begin
            if (!cur_eob) begin
              prev     <= cur_x;
              position <= pos_end;
              state    <= S_IDLE;
            end else if (alive) begin
              prev  <= cur_x;
              state <= S_HELD;
            end else begin
              prev     <= '0;
              position <= '0;
              state    <= S_IDLE;
            end
          end
        end
        S_HELD: begin
          if (!cond_h) begin
            prev     <= '0;
            position <= '0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      cur_x   <= q_sample;
      cur_eob <= q_ctl.eob;
      n       <= '0;
      diff    <= {q_sample[SAMPLE_BITS-1], q_sample} - {prev[SAMPLE_BITS-1], prev};
      if (q_ctl.kind == KIND_RUN) begin
        pos  <= position;
        psum <= position + step_ext;
      end else begin
        pos  <= '0;
        psum <= step_ext;
      end
    end else if (issue) begin
      n    <= n1;
      pos  <= psum;
      psum <= psum2;
    end else if ((state == S_INTERP) && !cond_i) begin
      pos  <= pos_end;
      psum <= psum_end;
    end
  end

  // multiply stage; held samples go through with a zero product
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      if (state == S_INTERP) begin
        prod   <= $signed({1'b0, pos[FRAC_BITS-1:0]}) * diff;
        p_base <= prev;
      end else begin
        prod   <= '0;
        p_base <= cur_x;
      end
      p_last <= issue_last;
      p_done <= issue_last && cur_eob;
    end
  end

  assign wsum = {{2{p_base[SAMPLE_BITS-1]}}, p_base} + prod[PROD_W-1:FRAC_BITS];

  // result queue
  assign empty       = (o_cnt == '0);
  assign o_pop       = pop && !empty;
  assign out_sample  = o_smp[o_rd];
  assign run_last    = o_last[o_rd];
  assign buffer_done = o_done[o_rd];

  always_ff @(posedge clk) begin
    if (v1) begin
      o_smp[o_wr]  <= wsum[SAMPLE_BITS-1:0];
      o_last[o_wr] <= p_last;
      o_done[o_wr] <= p_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr  <= '0;
      o_rd  <= '0;
      o_cnt <= '0;
    end else begin
      if (v1) begin
        o_wr <= (o_wr == OPTR_W'(OUT_DEPTH - 1)) ? '0 : o_wr + 1'b1;
      end
      if (o_pop) begin
        o_rd <= (o_rd == OPTR_W'(OUT_DEPTH - 1)) ? '0 : o_rd + 1'b1;
      end
      if (v1 && !o_pop) begin
        o_cnt <= o_cnt + 1'b1;
      end else if (o_pop && !v1) begin
        o_cnt <= o_cnt - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/lirs_checker.sv =====
module lirs_checker #(
  parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic signed [SAMPLE_BITS-1:0] out_sample,
  input logic                          run_last,
  input logic                          buffer_done
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results present after reset");

  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && buffer_done) |-> run_last)
    else $error("buffer_done without run_last");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_sample) && $stable(run_last)))
    else $error("waiting item changed");

endmodule

bind linear_interp_resampler_unit lirs_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_lirs_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_sample (out_sample),
  .run_last   (run_last),
  .buffer_done(buffer_done)
);

// ===== bench/linear_interp_resampler_unit_test.sv =====
module linear_interp_resampler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = lirs_pkg::SAMPLE_BITS_DEF;
  localparam int FB = lirs_pkg::FRAC_BITS_DEF;
  localparam int RUN_CAP = lirs_pkg::MAX_RUN_DEF;
  localparam logic [21:0] ONE = 22'd1 << FB;
  localparam logic [FB+3:0] STEP_RESET = 20'd65536;
  localparam int LIMIT = 400000;
  localparam int SETTLE = 40;

  typedef struct packed {
    logic signed [SB-1:0] smp;
    logic                 eob;
  } in_item_t;

  typedef struct packed {
    logic signed [SB-1:0] smp;
    logic                 last;
    logic                 done;
  } out_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic step_wr = 1'b0;
  logic [FB+3:0] step_in = '0;
  logic push = 1'b0;
  logic full;
  logic signed [SB-1:0] in_sample = '0;
  logic end_of_buffer = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [SB-1:0] out_sample;
  logic run_last;
  logic buffer_done;

  linear_interp_resampler_unit u_top (
    .clk(clk),
    .rst(rst),
    .step_wr(step_wr),
    .step(step_in),
    .push(push),
    .full(full),
    .in_sample(in_sample),
    .end_of_buffer(end_of_buffer),
    .empty(empty),
    .pop(pop),
    .out_sample(out_sample),
    .run_last(run_last),
    .buffer_done(buffer_done)
  );

  initial forever #5 clk = ~clk;

  // predictor state
  logic [FB+3:0] step_q = STEP_RESET;
  logic signed [SB-1:0] prev_q = '0;
  bit have_q = 1'b0;
  logic [21:0] pos_q = '0;

  in_item_t sample_feed[$];
  out_item_t resampled_q[$];
  in_item_t feed_item;
  out_item_t got;
  bit took = 1'b0;
  int send_idle = 9;
  int recv_idle = 88;
  int hold_left = 0;
  int cycles = 0;
  int mismatches = 0;
  int n_items = 0;
  int n_eob = 0;
  int n_results = 0;
  int longest_run = 0;

  task automatic resample(input in_item_t it);
    out_item_t r;
    int n;
    bit alive;
    longint diff, prod;
    n = 0;
    alive = 1'b1;
    r.last = 1'b0;
    r.done = 1'b0;
    if (!have_q) begin
      prev_q = it.smp;
      have_q = 1'b1;
    end else begin
      while (pos_q < ONE && n < RUN_CAP && (!it.eob || pos_q + step_q <= 2 * ONE)) begin
        diff = longint'(it.smp) - longint'(prev_q);
        prod = longint'(pos_q[FB-1:0]) * diff;
        r.smp = SB'(longint'(prev_q) + (prod >>> FB));
        resampled_q.push_back(r);
        n++;
        pos_q = pos_q + step_q;
      end
      if (pos_q < ONE) begin
        if (n >= RUN_CAP) pos_q = ONE;
        else alive = 1'b0;
      end
      if (alive) pos_q = pos_q - ONE;
      prev_q = it.smp;
    end
    if (it.eob) begin
      // flush: repeat the held sample for the rest of the buffer
      if (alive) begin
        while (n < RUN_CAP && pos_q + step_q <= ONE) begin
          r.smp = it.smp;
          resampled_q.push_back(r);
          n++;
          pos_q = pos_q + step_q;
        end
      end
      prev_q = '0;
      have_q = 1'b0;
      pos_q = '0;
      n_eob++;
    end
    if (n > 0) begin
      r = resampled_q.pop_back();
      r.last = 1'b1;
      r.done = it.eob;
      resampled_q.push_back(r);
    end
    if (n > longest_run) longest_run = n;
  endtask

  task automatic note_mismatch(input string what, input out_item_t want);
    if (mismatches < 10) begin
      $display("%0t %s: got sample %0d last %0b done %0b, want sample %0d last %0b done %0b",
               $realtime, what, out_sample, run_last, buffer_done,
               want.smp, want.last, want.done);
    end
    mismatches++;
  endtask

  // accept side: predictor update and result check
  always @(posedge clk) begin
    if (rst) begin
      step_q = STEP_RESET;
      prev_q = '0;
      have_q = 1'b0;
      pos_q = '0;
      took = 1'b0;
    end else begin
      if (step_wr) step_q = step_in;
      if (push && !full) begin
        resample({in_sample, end_of_buffer});
        took = 1'b1;
        n_items++;
      end
      if (pop && !empty) begin
        n_results++;
        if (resampled_q.size() == 0) begin
          note_mismatch("unexpected item", '0);
        end else begin
          got = resampled_q.pop_front();
          if (out_sample !== got.smp || run_last !== got.last || buffer_done !== got.done)
            note_mismatch("mismatch", got);
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || took) begin
      if (sample_feed.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        feed_item = sample_feed.pop_front();
        push <= 1'b1;
        in_sample <= feed_item.smp;
        end_of_buffer <= feed_item.eob;
      end else begin
        push <= 1'b0;
      end
    end
    took = 1'b0;
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left > 0) hold_left = hold_left - 1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, resampled_q.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic feed(input logic signed [SB-1:0] smp, input logic eob);
    sample_feed.push_back({smp, eob});
  endtask

  task automatic write_step(input logic [FB+3:0] v);
    @(negedge clk);
    step_wr <= 1'b1;
    step_in <= v;
    @(negedge clk);
    step_wr <= 1'b0;
  endtask

  task automatic drain();
    while (sample_feed.size() != 0 || push || resampled_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 64)) - 24'd32;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [FB+3:0] rand_step();
    case ($urandom_range(0, 5))
      0: return 20'd8192;
      1: return 20'd1048575;
      2: return 20'($urandom_range(8192, 1048575));
      default: return 20'($urandom_range(12000, 180000));
    endcase
  endfunction

  // buffers of random length, a few left open so they run into the next
  task automatic load_buffers(input int count);
    int len;
    int total;
    bit open;
    total = 0;
    while (total < count) begin
      len = $urandom_range(0, 5) == 0 ? 1 : $urandom_range(2, 10);
      open = $urandom_range(0, 7) == 0;
      for (int i = 0; i < len; i++) feed(rand_sample(), !open && i == len - 1);
      total += len;
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // unit step after reset: extremes, first sample, buffer end
    feed(24'sd100, 1'b0);
    feed(24'h7FFFFF, 1'b0);
    feed(24'h800000, 1'b0);
    feed(-24'sd1, 1'b0);
    feed(24'sd0, 1'b0);
    feed(24'sd5, 1'b1);
    feed(24'h800000, 1'b1);
    drain();

    // finest step: full-scale swings, flush hits the run cap
    write_step(20'd8192);
    feed(24'h7FFFFF, 1'b0);
    feed(24'h800000, 1'b0);
    feed(24'h7FFFFF, 1'b1);
    drain();

    // coarsest step: end of buffer with nothing left to emit
    write_step(20'd1048575);
    feed(24'sd1, 1'b0);
    feed(24'sd2, 1'b0);
    feed(24'sd3, 1'b1);
    drain();

    // step above 2.0 on a short buffer
    write_step(20'd229376);
    feed(24'sd10, 1'b0);
    feed(24'sd20, 1'b0);
    feed(24'sd30, 1'b1);
    feed(24'sd7, 1'b1);
    drain();

    // fractional step, rounding toward minus infinity
    write_step(20'd98304);
    feed(24'sd1000, 1'b0);
    feed(-24'sd1000, 1'b0);
    feed(24'sd3, 1'b0);
    feed(-24'sd3, 1'b1);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle = 88;
        recv_idle = 9;
      end
      if (ph == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_step(ph == 7 ? 20'd16384 : rand_step());
      load_buffers(19);
      if (ph == 7) begin
        @(posedge clk);
        #1 hold_left = 400;
      end
      drain();
    end

    $display("%0d items in, %0d buffer ends, %0d results checked, longest run %0d",
             n_items, n_eob, n_results, longest_run);
    $display("%0d mismatches, %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
